@@ design/sbit_pkg.sv @@
// Package for the segment/box intersection test: coordinate types, the beat
// layout of a query and the exact orientation predicate.
// No dependencies.
`default_nettype none

package sbit_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;

  typedef struct packed {
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t seg_start_x;
    coord_t seg_start_y;
    coord_t seg_end_x;
    coord_t seg_end_y;
  } query_t;

  // true when (cy - ay) * (bx - ax) > (by - ay) * (cx - ax), exactly
  function automatic logic orient(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                  coord_t cx, coord_t cy);
    diff_t d0;
    diff_t d1;
    diff_t d2;
    diff_t d3;
    prod_t p;
    prod_t q;
    d0 = diff_t'(cy) - diff_t'(ay);
    d1 = diff_t'(bx) - diff_t'(ax);
    d2 = diff_t'(by) - diff_t'(ay);
    d3 = diff_t'(cx) - diff_t'(ax);
    p  = prod_t'(d0) * prod_t'(d1);
    q  = prod_t'(d2) * prod_t'(d3);
    return p > q;
  endfunction

  // strict crossing of segment p1-p2 with segment q1-q2
  function automatic logic crosses(coord_t p1x, coord_t p1y, coord_t p2x, coord_t p2y,
                                   coord_t q1x, coord_t q1y, coord_t q2x, coord_t q2y);
    logic a;
    logic b;
    a = orient(p1x, p1y, q1x, q1y, q2x, q2y) != orient(p2x, p2y, q1x, q1y, q2x, q2y);
    b = orient(p1x, p1y, p2x, p2y, q1x, q1y) != orient(p1x, p1y, p2x, p2y, q2x, q2y);
    return a && b;
  endfunction

endpackage

`default_nettype wire

@@ design/sbit_if.sv @@
// Stream channels of the segment/box intersection test: query beats in,
// hit beats out. Depends on sbit_pkg.
`default_nettype none

interface sbit_query_if;
  import sbit_pkg::*;
  logic   valid;
  logic   ready;
  query_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface sbit_result_if;
  logic valid;
  logic ready;
  logic hit;
  modport source (output valid, output hit, input ready);
  modport sink (input valid, input hit, output ready);
endinterface

`default_nettype wire

@@ design/segment_box_intersection_test_unit.sv @@
// Segment versus axis-aligned box hit test, top level.
// Depends on sbit_pkg and the channels in sbit_if.
//
// One query beat is taken every cycle while the output is not stalled; its hit
// beat passes through the input register and then the result register. The
// hit is computed in a single pass through the bounding-box reject, the
// inclusive endpoint test and sixteen exact orientation compares (two
// 17x17 products each) between those two registers. Output stalls hold the
// pipeline; there is no state beyond the two stages.
`default_nettype none

module segment_box_intersection_test_unit (
  input wire logic    clk,
  input wire logic    rst,
  sbit_query_if.sink  query,
  sbit_result_if.source result
);
  import sbit_pkg::*;

  logic   s1_valid;
  query_t s1_item;
  logic   out_valid;
  logic   out_hit;

  logic   out_adv;
  logic   s1_adv;
  logic   hit_comb;

  coord_t lx0, lx1, ly0, ly1;
  logic   reject;
  logic   start_in, end_in;
  logic   [3:0] edge_x;

  assign out_adv     = !out_valid || result.ready;
  assign s1_adv      = !s1_valid || out_adv;
  assign query.ready = s1_adv;
  assign result.valid = out_valid;
  assign result.hit   = out_hit;

  always_comb begin
    lx0 = (s1_item.seg_start_x < s1_item.seg_end_x) ? s1_item.seg_start_x : s1_item.seg_end_x;
    lx1 = (s1_item.seg_start_x < s1_item.seg_end_x) ? s1_item.seg_end_x : s1_item.seg_start_x;
    ly0 = (s1_item.seg_start_y < s1_item.seg_end_y) ? s1_item.seg_start_y : s1_item.seg_end_y;
    ly1 = (s1_item.seg_start_y < s1_item.seg_end_y) ? s1_item.seg_end_y : s1_item.seg_start_y;
    reject = (lx1 < s1_item.box_min_x) || (lx0 > s1_item.box_max_x) ||
             (ly1 < s1_item.box_min_y) || (ly0 > s1_item.box_max_y);
    start_in = (s1_item.seg_start_x >= s1_item.box_min_x) &&
               (s1_item.seg_start_x <= s1_item.box_max_x) &&
               (s1_item.seg_start_y >= s1_item.box_min_y) &&
               (s1_item.seg_start_y <= s1_item.box_max_y);
    end_in   = (s1_item.seg_end_x >= s1_item.box_min_x) &&
               (s1_item.seg_end_x <= s1_item.box_max_x) &&
               (s1_item.seg_end_y >= s1_item.box_min_y) &&
               (s1_item.seg_end_y <= s1_item.box_max_y);
    edge_x[0] = crosses(s1_item.seg_start_x, s1_item.seg_start_y,
                        s1_item.seg_end_x, s1_item.seg_end_y,
                        s1_item.box_min_x, s1_item.box_min_y,
                        s1_item.box_max_x, s1_item.box_min_y);
    edge_x[1] = crosses(s1_item.seg_start_x, s1_item.seg_start_y,
                        s1_item.seg_end_x, s1_item.seg_end_y,
                        s1_item.box_max_x, s1_item.box_min_y,
                        s1_item.box_max_x, s1_item.box_max_y);
    edge_x[2] = crosses(s1_item.seg_start_x, s1_item.seg_start_y,
                        s1_item.seg_end_x, s1_item.seg_end_y,
                        s1_item.box_max_x, s1_item.box_max_y,
                        s1_item.box_min_x, s1_item.box_max_y);
    edge_x[3] = crosses(s1_item.seg_start_x, s1_item.seg_start_y,
                        s1_item.seg_end_x, s1_item.seg_end_y,
                        s1_item.box_min_x, s1_item.box_max_y,
                        s1_item.box_min_x, s1_item.box_min_y);
    hit_comb = !reject && (start_in || end_in || (|edge_x));
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= query.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && query.valid) begin
      s1_item <= query.item;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid) begin
      out_hit <= hit_comb;
    end
  end

  a_rst_clears: assert property (@(posedge clk) rst |=> !s1_valid && !out_valid)
    else $error("pipeline not empty after reset");

  a_beat_enters: assert property (@(posedge clk) disable iff (rst)
    query.valid && query.ready |=> s1_valid)
    else $error("accepted beat lost in input stage");

  a_beat_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_adv |=> out_valid && (out_hit == $past(hit_comb)))
    else $error("result register does not hold the computed hit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready && s1_valid |=> s1_valid && out_valid)
    else $error("beat dropped while output stalled");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for segment_box_intersection_test_unit: directed and random
// segment/box queries, checked against an in-bench hit predictor.
// Depends on sbit_pkg, sbit_if and the top level of the block.

module tb_top;
  import sbit_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct {
    query_t q;
    logic   hit;
  } hit_rec_t;

  logic clk;
  logic rst;
  bit   quiet;

  sbit_query_if  query_ch ();
  sbit_result_if result_ch ();

  segment_box_intersection_test_unit dut (
    .clk    (clk),
    .rst    (rst),
    .query  (query_ch),
    .result (result_ch)
  );

  hit_rec_t pending_hits[$];
  hit_rec_t leftover;
  int       mismatches;
  int       queries_sent;
  int       results_checked;
  int       hits_seen;
  int       idle_cycles;
  int       stall_left;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // exact orientation: (cy - ay) * (bx - ax) > (by - ay) * (cx - ax)
  function automatic bit left_of(longint ax, longint ay, longint bx, longint by,
                                 longint cx, longint cy);
    return (cy - ay) * (bx - ax) > (by - ay) * (cx - ax);
  endfunction

  function automatic bit segments_cross(longint p1x, longint p1y, longint p2x, longint p2y,
                                        longint q1x, longint q1y, longint q2x, longint q2y);
    return (left_of(p1x, p1y, q1x, q1y, q2x, q2y) != left_of(p2x, p2y, q1x, q1y, q2x, q2y))
        && (left_of(p1x, p1y, p2x, p2y, q1x, q1y) != left_of(p1x, p1y, p2x, p2y, q2x, q2y));
  endfunction

  function automatic bit point_in_box(longint x, longint y, longint x0, longint y0,
                                      longint x1, longint y1);
    return x >= x0 && x <= x1 && y >= y0 && y <= y1;
  endfunction

  function automatic logic segment_hits_box(query_t q);
    longint x0, y0, x1, y1, sx, sy, ex, ey;
    longint lo_x, hi_x, lo_y, hi_y;
    longint corner_x[4];
    longint corner_y[4];
    x0 = longint'(q.box_min_x);
    y0 = longint'(q.box_min_y);
    x1 = longint'(q.box_max_x);
    y1 = longint'(q.box_max_y);
    sx = longint'(q.seg_start_x);
    sy = longint'(q.seg_start_y);
    ex = longint'(q.seg_end_x);
    ey = longint'(q.seg_end_y);
    lo_x = sx < ex ? sx : ex;
    hi_x = sx < ex ? ex : sx;
    lo_y = sy < ey ? sy : ey;
    hi_y = sy < ey ? ey : sy;
    if (hi_x < x0 || lo_x > x1 || hi_y < y0 || lo_y > y1) return 1'b0;
    if (point_in_box(sx, sy, x0, y0, x1, y1) || point_in_box(ex, ey, x0, y0, x1, y1))
      return 1'b1;
    corner_x[0] = x0; corner_y[0] = y0;
    corner_x[1] = x1; corner_y[1] = y0;
    corner_x[2] = x1; corner_y[2] = y1;
    corner_x[3] = x0; corner_y[3] = y1;
    for (int k = 0; k < 4; k++) begin
      if (segments_cross(sx, sy, ex, ey, corner_x[k], corner_y[k],
                         corner_x[(k + 1) % 4], corner_y[(k + 1) % 4]))
        return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic query_t make_query(int bx0, int by0, int bx1, int by1,
                                        int sx, int sy, int ex, int ey);
    query_t q;
    q.box_min_x   = coord_t'(bx0);
    q.box_min_y   = coord_t'(by0);
    q.box_max_x   = coord_t'(bx1);
    q.box_max_y   = coord_t'(by1);
    q.seg_start_x = coord_t'(sx);
    q.seg_start_y = coord_t'(sy);
    q.seg_end_x   = coord_t'(ex);
    q.seg_end_y   = coord_t'(ey);
    return q;
  endfunction

  function automatic int rnd_signed(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // mostly short, a few long
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_gap();
    if (quiet || $urandom_range(0, 99) < 55) return 0;
    return pick_idle_len();
  endfunction

  function automatic query_t random_query();
    query_t q;
    int     r, cx, cy, wx, hy, spread, tmp;
    r  = $urandom_range(0, 99);
    cx = rnd_signed(20000);
    cy = rnd_signed(20000);
    wx = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 1000);
    hy = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 1000);
    spread = ($urandom_range(0, 1) == 0) ? wx + hy + 200 : $urandom_range(200, 3000);
    q = make_query(cx - wx / 2, cy - hy / 2, cx + (wx + 1) / 2, cy + (hy + 1) / 2,
                   cx + rnd_signed(spread), cy + rnd_signed(spread),
                   cx + rnd_signed(spread), cy + rnd_signed(spread));
    if (r < 20) begin
      q = query_t'({$urandom(), $urandom(), $urandom(), $urandom()});
    end else if (r < 28) begin
      // inverted box on one axis
      if ($urandom_range(0, 1) == 0) begin
        tmp = q.box_min_x; q.box_min_x = q.box_max_x; q.box_max_x = coord_t'(tmp);
      end else begin
        tmp = q.box_min_y; q.box_min_y = q.box_max_y; q.box_max_y = coord_t'(tmp);
      end
    end else if (r < 36) begin
      q.seg_end_x = q.seg_start_x;
      q.seg_end_y = q.seg_start_y;
    end else if (r < 46) begin
      // run along a box side line
      if ($urandom_range(0, 1) == 0) begin
        q.seg_start_y = $urandom_range(0, 1) ? q.box_min_y : q.box_max_y;
        q.seg_end_y   = q.seg_start_y;
      end else begin
        q.seg_start_x = $urandom_range(0, 1) ? q.box_min_x : q.box_max_x;
        q.seg_end_x   = q.seg_start_x;
      end
    end
    return q;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_query(input query_t q);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      query_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    query_ch.valid <= 1'b1;
    query_ch.item  <= q;
    do @(posedge clk); while (!query_ch.ready);
    queries_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    query_ch.valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
  endtask

  // predict on accepted queries, then check accepted results
  always @(posedge clk) begin
    hit_rec_t rec;
    logic     accepted;
    accepted = 1'b0;
    if (!rst && query_ch.valid && query_ch.ready) begin
      rec.q   = query_ch.item;
      rec.hit = segment_hits_box(query_ch.item);
      pending_hits.push_back(rec);
      accepted = 1'b1;
    end
    if (!rst && result_ch.valid && result_ch.ready) begin
      accepted = 1'b1;
      if (pending_hits.size() == 0) begin
        report_mismatch($sformatf("unexpected hit beat %0b", result_ch.hit));
      end else begin
        rec = pending_hits.pop_front();
        results_checked++;
        if (result_ch.hit === 1'b1) hits_seen++;
        if (result_ch.hit !== rec.hit)
          report_mismatch($sformatf("hit %0b, want %0b: box (%0d,%0d)-(%0d,%0d) seg (%0d,%0d)-(%0d,%0d)",
            result_ch.hit, rec.hit, rec.q.box_min_x, rec.q.box_min_y, rec.q.box_max_x,
            rec.q.box_max_y, rec.q.seg_start_x, rec.q.seg_start_y, rec.q.seg_end_x,
            rec.q.seg_end_y));
      end
    end
    idle_cycles = accepted ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               idle_cycles, pending_hits.size());
      $display("segment_box_intersection_test_unit test failed");
      $finish;
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (quiet) begin
      stall_left = 0;
      result_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 25) begin
      stall_left = pick_idle_len() - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  task automatic test_bounding_reject();
    send_query(make_query(0, 0, 10, 10, 20, 20, 30, 30));
    send_query(make_query(0, 0, 10, 10, -20, 0, -11, 10));
    send_query(make_query(0, 0, 10, 10, 0, 11, 10, 40));
  endtask

  task automatic test_endpoint_inside();
    send_query(make_query(0, 0, 10, 10, 5, 5, 50, 50));
    send_query(make_query(0, 0, 10, 10, 50, 50, 10, 10));
    send_query(make_query(0, 0, 10, 10, 1, 1, 9, 9));
  endtask

  task automatic test_edge_crossing();
    send_query(make_query(0, 0, 10, 10, -5, 5, 15, 5));
    send_query(make_query(0, 0, 10, 10, -5, 12, 12, -5));
    send_query(make_query(0, 0, 10, 10, -10, 5, 5, -10));
    send_query(make_query(0, 0, 10, 10, 5, -20, 5, 30));
  endtask

  task automatic test_corner_cases();
    send_query(make_query(10, 0, 0, 10, 5, 5, 6, 6));
    send_query(make_query(0, 10, 10, 0, -5, 5, 15, 5));
    send_query(make_query(0, 0, 10, 10, -5, 0, 15, 0));
    send_query(make_query(0, 0, 10, 10, 10, -5, 10, 15));
    send_query(make_query(0, 0, 10, 10, 5, 5, 5, 5));
    send_query(make_query(0, 0, 10, 10, 20, 5, 20, 5));
    send_query(make_query(0, 0, 10, 10, 10, 3, 10, 3));
  endtask

  task automatic test_field_extremes();
    send_query(make_query(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767));
    send_query(make_query(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_query(make_query(-2, -2, 2, 2, -32768, -32768, 32767, 32767));
    send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0));
    send_query(make_query(-1, -1, -1, -1, -1, -1, -1, -1));
  endtask

  task automatic test_random_mixed(input int n);
    repeat (n) send_query(random_query());
  endtask

  task automatic test_back_to_back(input int n);
    quiet = 1'b1;
    repeat (n) send_query(random_query());
    quiet = 1'b0;
  endtask

  task automatic test_drain_pause(input int n);
    repeat (n) send_query(random_query());
    wait_drained();
    repeat (n) send_query(random_query());
  endtask

  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    quiet           = 1'b0;
    query_ch.valid  = 1'b0;
    query_ch.item   = '0;
    result_ch.ready = 1'b0;
    mismatches      = 0;
    queries_sent    = 0;
    results_checked = 0;
    hits_seen       = 0;
    idle_cycles     = 0;
    stall_left      = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_bounding_reject();
    test_endpoint_inside();
    test_edge_crossing();
    test_corner_cases();
    test_field_extremes();
    test_random_mixed(250);
    test_back_to_back(60);
    test_drain_pause(30);
    test_random_mixed(160);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (pending_hits.size() != 0) begin
      leftover = pending_hits.pop_front();
      report_mismatch($sformatf("missing hit beat, want %0b", leftover.hit));
    end

    $display("covered %0d queries, %0d checked (%0d hits, %0d misses): directed corners,",
             queries_sent, results_checked, hits_seen, results_checked - hits_seen);
    $display("random, inverted and flat boxes, point and side-line segments, stalled and back-to-back beats");
    if (mismatches == 0) begin
      $display("segment_box_intersection_test_unit test passed");
    end else begin
      $display("segment_box_intersection_test_unit test failed");
    end
    $finish;
  end

endmodule
